// File: rtl/gaussian_noise_adder_macros.svh
`ifndef GAUSSIAN_NOISE_ADDER_MACROS_SVH
`define GAUSSIAN_NOISE_ADDER_MACROS_SVH

// same-cycle implication, checked outside reset
`define GNA_ASSERT_NOW(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) else $error(msg);

// next-cycle implication, checked outside reset
`define GNA_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) else $error(msg);

`endif

// File: rtl/gna_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gna_pkg;

  localparam int SUM_TERMS = 12;

  localparam int SAMPLE_W = 24;
  localparam int NOISE_W  = 20;
  localparam int STDDEV_W = 16;
  localparam int STATE_W  = 32;
  localparam int UNI_W    = 24;
  localparam int FRAC_W   = 24;

  localparam int CNT_W = (SUM_TERMS > 2) ? $clog2(SUM_TERMS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SUM_TERMS - 1);

  // centered sum of uniforms, signed, carries the -SUM_TERMS/2 offset
  localparam int SUM_W = UNI_W + $clog2(SUM_TERMS);
  localparam int Z_W   = SUM_W + 1;
  localparam logic signed [Z_W-1:0] Z_INIT = Z_W'(-(SUM_TERMS * (2 ** (UNI_W - 1))));

  // shared multiplier operand widths
  localparam int MUL_A_W = STATE_W + 1;
  localparam int MUL_B_W = 22;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [STATE_W-1:0]  LCG_MUL     = 32'd1664525;
  localparam logic [STATE_W-1:0]  LCG_INC     = 32'd1013904223;
  localparam logic [STATE_W-1:0]  SEED_RESET  = 32'h13579BDF;
  localparam logic [STDDEV_W-1:0] STDDEV_RESET = 16'd256;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STDDEV = 2'd0,
    REG_SEED   = 2'd1
  } reg_idx_t;

  typedef struct packed {
    logic                seed_load;
    logic [STATE_W-1:0]  seed;
    logic [STDDEV_W-1:0] stddev;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] noisy;
    logic signed [NOISE_W-1:0]  noise;
    logic                       clipped;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/gna_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module gna_mul (
  input  wire logic signed [gna_pkg::MUL_A_W-1:0] a,
  input  wire logic signed [gna_pkg::MUL_B_W-1:0] b,
  output      logic signed [gna_pkg::MUL_P_W-1:0] p
);
  import gna_pkg::*;

  // one signed multiplier, shared by the generator steps and the scaling
  always_comb begin
    p = MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

`default_nettype wire

// File: rtl/gna_core.sv
`timescale 1ns / 1ps
`default_nettype none

`include "gaussian_noise_adder_macros.svh"

module gna_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire gna_pkg::cfg_t                  cfg,
  input  wire logic                           start,
  input  wire logic signed [gna_pkg::SAMPLE_W-1:0] sample_in,
  input  wire logic                           out_free,
  output      logic                           idle,
  output      logic                           out_load,
  output      gna_pkg::res_t                  res
);
  import gna_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_LAST,
    S_SCALE,
    S_FINISH
  } state_t;

  state_t                     state;
  logic [CNT_W-1:0]           cnt;
  logic [STATE_W-1:0]         gen;
  logic signed [Z_W-1:0]      zsum;
  logic signed [SAMPLE_W-1:0] sample;
  logic signed [MUL_P_W-1:0]  prod;

  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [MUL_P_W-1:0]  mul_p;
  logic signed [Z_W-1:0]      uni;
  logic signed [NOISE_W-1:0]  noise;
  logic signed [SAMPLE_W:0]   total;
  res_t                       res_next;

  gna_mul u_mul (
    .a(mul_a),
    .b(mul_b),
    .p(mul_p)
  );

  always_comb begin
    if (state == S_SCALE) begin
      mul_a = MUL_A_W'(zsum);
      mul_b = $signed({{(MUL_B_W - STDDEV_W){1'b0}}, cfg.stddev});
    end else begin
      mul_a = $signed({1'b0, gen});
      mul_b = $signed(LCG_MUL[MUL_B_W-1:0]);
    end
  end

  // top bits of the generator as a Q0.24 fraction
  assign uni = $signed({{(Z_W - UNI_W){1'b0}}, gen[STATE_W-1 -: UNI_W]});

  // arithmetic shift of the product is a floor
  assign noise = prod[FRAC_W + NOISE_W - 1 : FRAC_W];

  always_comb begin
    total = (SAMPLE_W + 1)'(sample) + (SAMPLE_W + 1)'(noise);
    res_next.noise   = noise;
    res_next.clipped = total[SAMPLE_W] != total[SAMPLE_W-1];
    if (!res_next.clipped) begin
      res_next.noisy = total[SAMPLE_W-1:0];
    end else if (total[SAMPLE_W]) begin
      res_next.noisy = {1'b1, {(SAMPLE_W - 1){1'b0}}};
    end else begin
      res_next.noisy = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    end
  end

  assign idle     = state == S_IDLE;
  assign out_load = (state == S_FINISH) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      gen   <= SEED_RESET;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg.seed_load) begin
            gen <= cfg.seed;
          end
          if (start) begin
            sample <= sample_in;
            zsum   <= Z_INIT;
            cnt    <= '0;
            state  <= S_STEP;
          end
        end
        S_STEP: begin
          gen <= mul_p[STATE_W-1:0] + LCG_INC;
          // fold in the previous step's output, one step behind
          if (cnt != '0) begin
            zsum <= zsum + uni;
          end
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          zsum  <= zsum + uni;
          state <= S_SCALE;
        end
        S_SCALE: begin
          prod  <= mul_p;
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            res   <= res_next;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `GNA_ASSERT_NOW(a_start_idle, start, state == S_IDLE, "item started while busy")
  `GNA_ASSERT_NEXT(a_step_end, (state == S_STEP) && (cnt == CNT_LAST), state == S_LAST, "step count overrun")
  `GNA_ASSERT_NEXT(a_load_idle, out_load, state == S_IDLE, "result load did not end the item")
  `GNA_ASSERT_NOW(a_load_free, out_load, out_free, "result loaded over a waiting item")

endmodule

`default_nettype wire

// File: rtl/gaussian_noise_adder.sv
`timescale 1ns / 1ps
`default_nettype none
// per item in turn: 12 generator steps, the last sum, the scaling, then the add
// one item at a time: a new sample is taken only once the last one is done, set by the single
//   shared multiplier that runs the generator steps one after another and then the scaling
// in_ready is high only while the sequencer is idle; a finished item waits in the output register
// synchronous reset: stddev 256, generator state 0x13579BDF, no item held

module gaussian_noise_adder (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [gna_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [gna_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic                                 in_valid,
  output      logic                                 in_ready,
  input  wire logic signed [gna_pkg::SAMPLE_W-1:0]  clean_sample,
  output      logic                                 out_valid,
  input  wire logic                                 out_ready,
  output      logic signed [gna_pkg::SAMPLE_W-1:0]  noisy_sample,
  output      logic signed [gna_pkg::NOISE_W-1:0]   noise_value,
  output      logic                                 clipped
);
  import gna_pkg::*;

  logic [STDDEV_W-1:0] noise_stddev;
  cfg_t                cfg;
  logic                core_idle;
  logic                out_load;
  logic                out_free;
  res_t                res;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_stddev <= STDDEV_RESET;
    end else if (cfg_we && (cfg_index == REG_STDDEV)) begin
      noise_stddev <= cfg_data[STDDEV_W-1:0];
    end
  end

  always_comb begin
    cfg.seed_load = cfg_we && (cfg_index == REG_SEED);
    cfg.seed      = cfg_data[STATE_W-1:0];
    cfg.stddev    = noise_stddev;
  end

  assign in_ready = core_idle;
  assign out_free = !out_valid || out_ready;

  gna_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .start    (in_valid && in_ready),
    .sample_in(clean_sample),
    .out_free (out_free),
    .idle     (core_idle),
    .out_load (out_load),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign noisy_sample = res.noisy;
  assign noise_value  = res.noise;
  assign clipped      = res.clipped;

endmodule

`default_nettype wire

// File: tb/gaussian_noise_adder_tb.sv
`timescale 1ns / 1ps

module gaussian_noise_adder_tb;
  import gna_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int DIR_ROWS = 26;
  localparam res_t NO_RES = '0;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    row_kind_t                  kind;
    logic [CFG_IDX_W-1:0]       idx;
    logic [CFG_DATA_W-1:0]      data;
    logic signed [SAMPLE_W-1:0] sample;
    bit                         known;
    res_t                       exp_res;
  } dir_row_t;

  // rows with stddev 0 carry their result: no noise, sample passes through
  dir_row_t dir_rows [0:DIR_ROWS-1] = '{
    '{ROW_ITEM, REG_STDDEV, 32'd0, 24'sd0, 1'b0, NO_RES},
    '{ROW_ITEM, REG_STDDEV, 32'd0, 24'sh7FFFFF, 1'b0, NO_RES},
    '{ROW_CFG, REG_STDDEV, 32'd0, 24'sd0, 1'b0, NO_RES},
    '{ROW_ITEM, REG_STDDEV, 32'd0, 24'sh7FFFFF, 1'b1, '{24'sh7FFFFF, 20'sd0, 1'b0}},
    '{ROW_ITEM, REG_STDDEV, 32'd0, 24'sh800000, 1'b1, '{24'sh800000, 20'sd0, 1'b0}},
    '{ROW_ITEM, REG_STDDEV, 32'd0, 24'sd0, 1'b1, '{24'sd0, 20'sd0, 1'b0}},
    '{ROW_ITEM, REG_STDDEV, 32'd0, -24'sd1, 1'b1, '{-24'sd1, 20'sd0, 1'b0}},
    '{ROW_ITEM, REG_STDDEV, 32'd0, 24'sd1, 1'b1, '{24'sd1, 20'sd0, 1'b0}},
    '{ROW_ITEM, REG_STDDEV, 32'd0, 24'sh555555, 1'b1, '{24'sh555555, 20'sd0, 1'b0}},
    '{ROW_ITEM, REG_STDDEV, 32'd0, 24'shAAAAAA, 1'b1, '{24'shAAAAAA, 20'sd0, 1'b0}},
    '{ROW_CFG, REG_STDDEV, 32'h0000FFFF, 24'sd0, 1'b0, NO_RES},
    '{ROW_CFG, REG_SEED, 32'h00000000, 24'sd0, 1'b0, NO_RES},
    '{ROW_ITEM, REG_STDDEV, 32'd0, 24'sh7FFFFF, 1'b0, NO_RES},
    '{ROW_ITEM, REG_STDDEV, 32'd0, 24'sh800000, 1'b0, NO_RES},
    '{ROW_ITEM, REG_STDDEV, 32'd0, 24'sd0, 1'b0, NO_RES},
    '{ROW_CFG, REG_UNUSED_LO, 32'h00000000, 24'sd0, 1'b0, NO_RES},
    '{ROW_CFG, REG_UNUSED_HI, 32'hFFFFFFFF, 24'sd0, 1'b0, NO_RES},
    '{ROW_ITEM, REG_STDDEV, 32'd0, 24'sd8388000, 1'b0, NO_RES},
    '{ROW_ITEM, REG_STDDEV, 32'd0, -24'sd8388000, 1'b0, NO_RES},
    '{ROW_CFG, REG_STDDEV, 32'd1, 24'sd0, 1'b0, NO_RES},
    '{ROW_CFG, REG_SEED, 32'hFFFFFFFF, 24'sd0, 1'b0, NO_RES},
    '{ROW_ITEM, REG_STDDEV, 32'd0, -24'sd1, 1'b0, NO_RES},
    '{ROW_ITEM, REG_STDDEV, 32'd0, 24'sd1, 1'b0, NO_RES},
    '{ROW_CFG, REG_STDDEV, 32'd256, 24'sd0, 1'b0, NO_RES},
    '{ROW_CFG, REG_SEED, 32'h13579BDF, 24'sd0, 1'b0, NO_RES},
    '{ROW_ITEM, REG_STDDEV, 32'd0, 24'sd12345, 1'b0, NO_RES}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SAMPLE_W-1:0] clean_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] noisy_sample;
  logic signed [NOISE_W-1:0] noise_value;
  logic clipped;

  // predictor copy of the block's state and configuration
  logic [STATE_W-1:0] lcg_state = SEED_RESET;
  logic [STDDEV_W-1:0] stddev_cfg = STDDEV_RESET;

  res_t noisy_queue [$];
  int err_cnt = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // travel with the offered item, read at the accept edge
  bit item_known = 1'b0;
  res_t item_exp = '0;

  int hold_reqs = 0;
  int hold_seen;
  int hold_cnt;

  gaussian_noise_adder u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .clean_sample (clean_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .noisy_sample (noisy_sample),
    .noise_value  (noise_value),
    .clipped      (clipped)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic res_t add_gaussian_noise(input logic signed [SAMPLE_W-1:0] s);
    logic [STATE_W-1:0] st;
    longint acc;
    longint z;
    longint nz;
    longint total;
    res_t r;
    st = lcg_state;
    acc = 0;
    for (int i = 0; i < SUM_TERMS; i++) begin
      st = st * LCG_MUL + LCG_INC;
      acc = acc + longint'(st[STATE_W-1:8]);
    end
    lcg_state = st;
    z = acc - longint'(SUM_TERMS) * 64'sd8388608;
    // arithmetic shift floors negative products as well
    nz = (z * longint'(stddev_cfg)) >>> FRAC_W;
    total = longint'(s) + nz;
    r.clipped = 1'b0;
    if (total > 64'sd8388607) begin
      total = 64'sd8388607;
      r.clipped = 1'b1;
    end else if (total < -64'sd8388608) begin
      total = -64'sd8388608;
      r.clipped = 1'b1;
    end
    r.noisy = total[SAMPLE_W-1:0];
    r.noise = nz[NOISE_W-1:0];
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    logic signed [SAMPLE_W-1:0] v;
    case ($urandom_range(3))
      0: v = 24'($urandom());
      1: v = 24'sh7FFFFF - 24'($urandom_range(400000));
      2: v = 24'sh800000 + 24'($urandom_range(400000));
      default: v = 24'($urandom_range(8191)) - 24'sd4096;
    endcase
    return v;
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] v, input bit known,
                             input res_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    clean_sample <= v;
    item_known <= known;
    item_exp <= e;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (noisy_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_cnt <= 0;
      hold_seen <= 0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_cnt <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    res_t want;
    if (rst) begin
      lcg_state = SEED_RESET;
      stddev_cfg = STDDEV_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_STDDEV: stddev_cfg = cfg_data[STDDEV_W-1:0];
          REG_SEED: lcg_state = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (noisy_queue.size() == 0) begin
          $error("unexpected item: noisy_sample %0d noise_value %0d", noisy_sample,
                 noise_value);
          err_cnt++;
        end else begin
          want = noisy_queue.pop_front();
          if (noisy_sample !== want.noisy) begin
            $error("noisy_sample: expected %0d, got %0d", want.noisy, noisy_sample);
            err_cnt++;
          end
          if (noise_value !== want.noise) begin
            $error("noise_value: expected %0d, got %0d", want.noise, noise_value);
            err_cnt++;
          end
          if (clipped !== want.clipped) begin
            $error("clipped: expected %0b, got %0b", want.clipped, clipped);
            err_cnt++;
          end
        end
      end
      if (in_valid && in_ready) begin
        // the predictor always runs so the generator stays in step
        want = add_gaussian_noise(clean_sample);
        if (item_known) want = item_exp;
        noisy_queue.push_back(want);
      end
    end
  end

  initial begin : stimulus
    idle_mode_t mode;
    int n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        wait_drained();
        write_reg(dir_rows[r].idx, dir_rows[r].data);
      end else begin
        send_sample(dir_rows[r].sample, dir_rows[r].known, dir_rows[r].exp_res);
      end
    end

    for (int ph = 0; ph < 9; ph++) begin
      wait_drained();
      case ($urandom_range(5))
        0: write_reg(REG_STDDEV, 32'd0);
        1: write_reg(REG_STDDEV, 32'h0000FFFF);
        2: write_reg(REG_STDDEV, 32'd256);
        3: write_reg(REG_STDDEV, 32'($urandom_range(15)));
        default: write_reg(REG_STDDEV, 32'($urandom_range(16'hFFFF)));
      endcase
      case ($urandom_range(4))
        0: write_reg(REG_SEED, 32'h00000000);
        1: write_reg(REG_SEED, 32'hFFFFFFFF);
        2, 3: write_reg(REG_SEED, $urandom());
        default: ;
      endcase
      if ($urandom_range(3) == 0)
        write_reg($urandom_range(1) ? REG_UNUSED_HI : REG_UNUSED_LO, $urandom());

      mode = idle_mode_t'(ph % 4);
      case (mode)
        IDLE_NONE: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        IDLE_SEND: begin
          send_idle_pct = 73;
          recv_stall_pct = 0;
        end
        IDLE_RECV: begin
          send_idle_pct = 0;
          recv_stall_pct = 73;
        end
        default: begin
          send_idle_pct = 37;
          recv_stall_pct = 37;
        end
      endcase
      n = 140;
      if (ph == 8) begin
        // long receiver hold-off while items keep coming, block backs up
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_reqs <= hold_reqs + 1;
        n = 130;
      end
      repeat (n) send_sample(rand_sample(), 1'b0, NO_RES);
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (err_cnt == 0 && noisy_queue.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/gna_pkg.sv
rtl/gna_mul.sv
rtl/gna_core.sv
rtl/gaussian_noise_adder.sv
tb/gaussian_noise_adder_tb.sv
